// ===== rtl/core/asp_pkg.sv =====
// annulus scan line spans: shared types and register index codes
// used by the front stage, the square-root cells, the back stage and the top level

package asp_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_OUTER_RADIUS = 3'd2,
    REG_INNER_RADIUS = 3'd3,
    REG_CLIP_LEFT    = 3'd4,
    REG_CLIP_RIGHT   = 3'd5,
    REG_CLIP_TOP     = 3'd6,
    REG_CLIP_BOTTOM  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic none;
    logic inner_ok;
  } side_t;

endpackage

// ===== rtl/core/asp_front.sv =====
// annulus scan line spans: front stages, line tests, |dy| and both radicands
// depends on asp_pkg

module asp_front
  import asp_pkg::*;
#(
  parameter int unsigned C = 16,
  parameter int unsigned F = 4,
  localparam int unsigned PW = C + F,
  localparam int unsigned RB = PW - 1,
  localparam int unsigned RW = 2 * RB
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [C-1:0]         line_y_i,
  input  logic signed [PW-1:0] cx_i,
  input  logic signed [PW-1:0] cy_i,
  input  logic [RB-1:0]        ro_i,
  input  logic [RB-1:0]        ri_i,
  input  logic signed [C-1:0]  clip_left_i,
  input  logic signed [C-1:0]  clip_right_i,
  input  logic signed [C-1:0]  clip_top_i,
  input  logic signed [C-1:0]  clip_bottom_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output side_t                out_side_o,
  output logic [RW-1:0]        out_rad_outer_o,
  output logic [RW-1:0]        out_rad_inner_o
);

  localparam logic signed [PW+1:0] Bias = (PW+2)'((1 << F) - 1);

  logic signed [C-1:0]  y;
  logic signed [PW:0]   y_sc;
  logic signed [PW:0]   cy_x;
  logic signed [PW:0]   dy;
  logic [PW:0]          ady_w;
  logic signed [PW:0]   cx_x1;
  logic signed [PW:0]   ro_x1;
  logic signed [PW:0]   lo_sum;
  logic signed [PW:0]   lo_pix;
  logic signed [PW:0]   cr_x;
  logic signed [PW+1:0] cx_x2;
  logic signed [PW+1:0] ro_x2;
  logic signed [PW+1:0] hi_sum;
  logic signed [PW+1:0] hi_pix;
  logic signed [PW+1:0] cl_x;
  logic                 none_w;
  logic                 inner_ok_w;

  logic          v1_q, v2_q;
  logic          r1, r2;
  side_t         side1_q, side1_d, side2_q;
  logic [RB-1:0] ady1_q, ady1_d;
  logic [RW-1:0] ro_sq_q, ri_sq_q;
  logic [RW-1:0] ady_sq;
  logic [RW-1:0] rad_o_q, rad_o_d, rad_i_q, rad_i_d;

  assign y      = $signed(line_y_i);
  assign y_sc   = $signed({{(F+1){line_y_i[C-1]}}, line_y_i}) <<< F;
  assign cy_x   = $signed({cy_i[PW-1], cy_i});
  assign dy     = y_sc - cy_x;
  assign ady_w  = dy[PW] ? (PW+1)'(-dy) : (PW+1)'(dy);

  assign cx_x1  = $signed({cx_i[PW-1], cx_i});
  assign ro_x1  = $signed({2'b00, ro_i});
  assign lo_sum = cx_x1 - ro_x1;
  assign lo_pix = lo_sum >>> F;
  assign cr_x   = $signed({{(PW+1-C){clip_right_i[C-1]}}, clip_right_i});

  assign cx_x2  = $signed({{2{cx_i[PW-1]}}, cx_i});
  assign ro_x2  = $signed({3'b000, ro_i});
  assign hi_sum = cx_x2 + ro_x2 + Bias;
  assign hi_pix = hi_sum >>> F;
  assign cl_x   = $signed({{(PW+2-C){clip_left_i[C-1]}}, clip_left_i});

  assign none_w = (clip_left_i >= clip_right_i) || (y < clip_top_i) || (y >= clip_bottom_i)
               || (lo_pix >= cr_x) || (hi_pix <= cl_x) || (ady_w > {2'b00, ro_i});
  assign inner_ok_w = ady_w <= {2'b00, ri_i};

  assign side1_d.none     = none_w;
  assign side1_d.inner_ok = inner_ok_w;
  assign ady1_d = none_w ? '0 : ady_w[RB-1:0];

  assign ady_sq  = RW'(ady1_q) * RW'(ady1_q);
  assign rad_o_d = ro_sq_q - ady_sq;
  assign rad_i_d = side1_q.inner_ok ? ri_sq_q - ady_sq : '0;

  assign r2 = !v2_q || out_ready_i;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ro_sq_q <= RW'(ro_i) * RW'(ro_i);
    ri_sq_q <= RW'(ri_i) * RW'(ri_i);
    if (r1 && in_valid_i) begin
      side1_q <= side1_d;
      ady1_q  <= ady1_d;
    end
    if (r2 && v1_q) begin
      side2_q <= side1_q;
      rad_o_q <= rad_o_d;
      rad_i_q <= rad_i_d;
    end
  end

  assign out_valid_o     = v2_q;
  assign out_side_o      = side2_q;
  assign out_rad_outer_o = rad_o_q;
  assign out_rad_inner_o = rad_i_q;

endmodule

// ===== rtl/core/asp_sqrt_cell.sv =====
// annulus scan line spans: one cell of the square-root chain, settles one root bit
// for the outer and the inner radicand; depends on asp_pkg

module asp_sqrt_cell
  import asp_pkg::*;
#(
  parameter int unsigned RB = 19,
  parameter int unsigned K = 0,
  localparam int unsigned RW = 2 * RB
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  side_t         in_side_i,
  input  logic [RW-1:0] in_orem_i,
  input  logic [RB-1:0] in_oroot_i,
  input  logic [RW-1:0] in_irem_i,
  input  logic [RB-1:0] in_iroot_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output side_t         out_side_o,
  output logic [RW-1:0] out_orem_o,
  output logic [RB-1:0] out_oroot_o,
  output logic [RW-1:0] out_irem_o,
  output logic [RB-1:0] out_iroot_o
);

  logic [RW-1:0] trial_o, trial_i;
  logic [RW:0]   diff_o, diff_i;
  logic [RW-1:0] orem_d, irem_d;
  logic [RB-1:0] oroot_d, iroot_d;
  logic          valid_q, ready;
  side_t         side_q;
  logic [RW-1:0] orem_q, irem_q;
  logic [RB-1:0] oroot_q, iroot_q;

  // (q + 2^k)^2 - q^2 = q * 2^(k+1) + 2^(2k)
  assign trial_o = (RW'(in_oroot_i) << (K + 1)) | (RW'(1) << (2 * K));
  assign trial_i = (RW'(in_iroot_i) << (K + 1)) | (RW'(1) << (2 * K));
  assign diff_o  = {1'b0, in_orem_i} - {1'b0, trial_o};
  assign diff_i  = {1'b0, in_irem_i} - {1'b0, trial_i};

  always_comb begin
    orem_d     = diff_o[RW] ? in_orem_i : diff_o[RW-1:0];
    irem_d     = diff_i[RW] ? in_irem_i : diff_i[RW-1:0];
    oroot_d    = in_oroot_i;
    iroot_d    = in_iroot_i;
    oroot_d[K] = !diff_o[RW];
    iroot_d[K] = !diff_i[RW];
  end

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      side_q  <= in_side_i;
      orem_q  <= orem_d;
      irem_q  <= irem_d;
      oroot_q <= oroot_d;
      iroot_q <= iroot_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_side_o  = side_q;
  assign out_orem_o  = orem_q;
  assign out_oroot_o = oroot_q;
  assign out_irem_o  = irem_q;
  assign out_iroot_o = iroot_q;

endmodule

// ===== rtl/core/asp_back.sv =====
// annulus scan line spans: back stages, pixel ends, clamping and span selection
// depends on asp_pkg

module asp_back
  import asp_pkg::*;
#(
  parameter int unsigned C = 16,
  parameter int unsigned F = 4,
  localparam int unsigned PW = C + F,
  localparam int unsigned RB = PW - 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  side_t                in_side_i,
  input  logic [RB-1:0]        in_d_i,
  input  logic [RB-1:0]        in_di_i,
  input  logic signed [PW-1:0] cx_i,
  input  logic signed [C-1:0]  clip_left_i,
  input  logic signed [C-1:0]  clip_right_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 first_valid_o,
  output logic [C-1:0]         first_start_o,
  output logic [C-1:0]         first_end_o,
  output logic                 second_valid_o,
  output logic [C-1:0]         second_start_o,
  output logic [C-1:0]         second_end_o
);

  localparam int unsigned SW = PW + 2;
  localparam logic signed [SW-1:0] Bias     = SW'((1 << F) - 1);
  localparam logic signed [SW-1:0] CoordMax = SW'((1 << (C - 1)) - 1);
  localparam logic signed [SW-1:0] CoordMin = ~CoordMax;

  function automatic logic signed [SW-1:0] trunc_pix(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] b;
    b = x[SW-1] ? Bias : '0;
    return (x + b) >>> F;
  endfunction

  function automatic logic signed [SW-1:0] sat_pix(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] r;
    r = x;
    if (x > CoordMax) r = CoordMax;
    if (x < CoordMin) r = CoordMin;
    return r;
  endfunction

  logic signed [SW-1:0] cx_x, d_x, di_x, cl_x, cr_x;
  logic signed [SW-1:0] ol_w, or_w, il_w, ir_w;
  logic signed [SW-1:0] ol_c, or_c;

  logic               va_q, vb_q, ra, rb;
  logic               none_q, ring_q;
  logic signed [C-1:0] ol_q, or_q, il_q, ir_q;
  logic               fv_d, sv_d, fv_q, sv_q;
  logic [C-1:0]       fs_d, fe_d, ss_d, se_d;
  logic [C-1:0]       fs_q, fe_q, ss_q, se_q;

  assign cx_x = $signed({{2{cx_i[PW-1]}}, cx_i});
  assign d_x  = $signed({3'b000, in_d_i});
  assign di_x = $signed({3'b000, in_di_i});
  assign cl_x = $signed({{(SW-C){clip_left_i[C-1]}}, clip_left_i});
  assign cr_x = $signed({{(SW-C){clip_right_i[C-1]}}, clip_right_i});

  assign ol_w = trunc_pix(cx_x - d_x);
  assign or_w = trunc_pix(cx_x + d_x);
  assign il_w = trunc_pix(cx_x - di_x);
  assign ir_w = trunc_pix(cx_x + di_x);
  assign ol_c = (ol_w < cl_x) ? cl_x : ol_w;
  assign or_c = (or_w > cr_x) ? cr_x : or_w;

  always_comb begin
    fv_d = 1'b0;
    fs_d = '0;
    fe_d = '0;
    sv_d = 1'b0;
    ss_d = '0;
    se_d = '0;
    if (!none_q) begin
      if (ring_q) begin
        if (ol_q < il_q) begin
          fv_d = 1'b1;
          fs_d = ol_q;
          fe_d = il_q;
        end
        if (ir_q < or_q) begin
          sv_d = 1'b1;
          ss_d = ir_q;
          se_d = or_q;
        end
      end else if (ol_q < or_q) begin
        fv_d = 1'b1;
        fs_d = ol_q;
        fe_d = or_q;
      end
    end
  end

  assign rb = !vb_q || out_ready_i;
  assign ra = !va_q || rb;
  assign in_ready_o = ra;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ra) va_q <= in_valid_i;
      if (rb) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra && in_valid_i) begin
      none_q <= in_side_i.none;
      ring_q <= in_side_i.inner_ok && (il_w < ir_w);
      ol_q   <= ol_c[C-1:0];
      or_q   <= or_c[C-1:0];
      il_q   <= C'(sat_pix(il_w));
      ir_q   <= C'(sat_pix(ir_w));
    end
    if (rb && va_q) begin
      fv_q <= fv_d;
      fs_q <= fs_d;
      fe_q <= fe_d;
      sv_q <= sv_d;
      ss_q <= ss_d;
      se_q <= se_d;
    end
  end

  assign out_valid_o    = vb_q;
  assign first_valid_o  = fv_q;
  assign first_start_o  = fs_q;
  assign first_end_o    = fe_q;
  assign second_valid_o = sv_q;
  assign second_start_o = ss_q;
  assign second_end_o   = se_q;

endmodule

// ===== rtl/core/annulus_scanline_spans_top.sv =====
// annulus scan line spans: top level, configuration registers and the pipeline
// depends on asp_pkg, asp_front, asp_sqrt_cell and asp_back

// Takes one scan line per word and returns one word with up to two half-open pixel
// spans of a clipped disc or ring on that line. A new line is accepted in every
// cycle while the result stream is not stalled; each line passes through two front
// stages for the line tests and squares, one cell per root bit in the square-root
// chain (COORD_BITS+FRAC_BITS-1 cells), and two back stages.
// Every stage has its own valid bit, so bubbles close up while the output waits.
// Configuration writes are always taken and apply to lines accepted afterwards; write
// them only while no line is in flight.

module annulus_scanline_spans_top
  import asp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 4,
  localparam int unsigned C    = COORD_BITS,
  localparam int unsigned PW   = COORD_BITS + FRAC_BITS,
  localparam int unsigned RB   = PW - 1,
  localparam int unsigned RW   = 2 * RB,
  localparam int unsigned InW  = ((C + 7) / 8) * 8,
  localparam int unsigned OutW = ((4 * C + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PW-1:0]      cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InW-1:0]     s_axis_tdata,   // line_y
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OutW-1:0]    m_axis_tdata,   // first_start, first_end, second_start, second_end
  output logic [1:0]         m_axis_tuser    // first_valid, second_valid
);

  logic signed [PW-1:0] cx_q, cy_q;
  logic [RB-1:0]        ro_q, ri_q;
  logic signed [C-1:0]  clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q          <= '0;
      cy_q          <= '0;
      ro_q          <= '0;
      ri_q          <= '0;
      clip_left_q   <= {1'b1, {(C-1){1'b0}}};
      clip_right_q  <= {1'b0, {(C-1){1'b1}}};
      clip_top_q    <= {1'b1, {(C-1){1'b0}}};
      clip_bottom_q <= {1'b0, {(C-1){1'b1}}};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X:     cx_q          <= cfg_data_i;
        REG_CENTER_Y:     cy_q          <= cfg_data_i;
        REG_OUTER_RADIUS: ro_q          <= cfg_data_i[RB-1:0];
        REG_INNER_RADIUS: ri_q          <= cfg_data_i[RB-1:0];
        REG_CLIP_LEFT:    clip_left_q   <= cfg_data_i[C-1:0];
        REG_CLIP_RIGHT:   clip_right_q  <= cfg_data_i[C-1:0];
        REG_CLIP_TOP:     clip_top_q    <= cfg_data_i[C-1:0];
        REG_CLIP_BOTTOM:  clip_bottom_q <= cfg_data_i[C-1:0];
        default: ;
      endcase
    end
  end

  logic          valid_w [RB+1];
  logic          ready_w [RB+1];
  side_t         side_w  [RB+1];
  logic [RW-1:0] orem_w  [RB+1];
  logic [RW-1:0] irem_w  [RB+1];
  logic [RB-1:0] oroot_w [RB+1];
  logic [RB-1:0] iroot_w [RB+1];

  asp_front #(.C(C), .F(FRAC_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .line_y_i        (s_axis_tdata[C-1:0]),
    .cx_i            (cx_q),
    .cy_i            (cy_q),
    .ro_i            (ro_q),
    .ri_i            (ri_q),
    .clip_left_i     (clip_left_q),
    .clip_right_i    (clip_right_q),
    .clip_top_i      (clip_top_q),
    .clip_bottom_i   (clip_bottom_q),
    .out_valid_o     (valid_w[0]),
    .out_ready_i     (ready_w[0]),
    .out_side_o      (side_w[0]),
    .out_rad_outer_o (orem_w[0]),
    .out_rad_inner_o (irem_w[0])
  );

  assign oroot_w[0] = '0;
  assign iroot_w[0] = '0;

  for (genvar k = 0; k < RB; k++) begin : g_cell
    asp_sqrt_cell #(.RB(RB), .K(RB - 1 - k)) u_cell (
      .clk_i,
      .rst_ni,
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .in_side_i   (side_w[k]),
      .in_orem_i   (orem_w[k]),
      .in_oroot_i  (oroot_w[k]),
      .in_irem_i   (irem_w[k]),
      .in_iroot_i  (iroot_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .out_side_o  (side_w[k+1]),
      .out_orem_o  (orem_w[k+1]),
      .out_oroot_o (oroot_w[k+1]),
      .out_irem_o  (irem_w[k+1]),
      .out_iroot_o (iroot_w[k+1])
    );
  end

  logic         first_valid, second_valid;
  logic [C-1:0] first_start, first_end, second_start, second_end;

  asp_back #(.C(C), .F(FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i     (valid_w[RB]),
    .in_ready_o     (ready_w[RB]),
    .in_side_i      (side_w[RB]),
    .in_d_i         (oroot_w[RB]),
    .in_di_i        (iroot_w[RB]),
    .cx_i           (cx_q),
    .clip_left_i    (clip_left_q),
    .clip_right_i   (clip_right_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .first_valid_o  (first_valid),
    .first_start_o  (first_start),
    .first_end_o    (first_end),
    .second_valid_o (second_valid),
    .second_start_o (second_start),
    .second_end_o   (second_end)
  );

  assign m_axis_tdata = OutW'({second_end, second_start, first_end, first_start});
  assign m_axis_tuser = {second_valid, first_valid};

endmodule

// ===== rtl/core/asp_checker.sv =====
// annulus scan line spans: port checker on the result stream, bound to the top level
// depends only on the top level's ports

module asp_checker #(
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned C    = COORD_BITS,
  localparam int unsigned OutW = ((4 * C + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic [1:0]      m_axis_tuser
);

  logic signed [C-1:0] fs, fe, ss, se;

  assign fs = $signed(m_axis_tdata[C-1:0]);
  assign fe = $signed(m_axis_tdata[2*C-1:C]);
  assign ss = $signed(m_axis_tdata[3*C-1:2*C]);
  assign se = $signed(m_axis_tdata[4*C-1:3*C]);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_first_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> fs == '0 && fe == '0)
    else $error("absent first span carries nonzero ends");

  a_second_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> ss == '0 && se == '0)
    else $error("absent second span carries nonzero ends");

  a_first_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> fs < fe)
    else $error("first span is empty");

  a_second_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> ss < se)
    else $error("second span is empty");

endmodule

bind annulus_scanline_spans_top asp_checker #(.COORD_BITS(COORD_BITS)) u_asp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
// testbench for annulus_scanline_spans_top: random and directed scan lines against a span predictor
// depends on asp_pkg and the annulus_scanline_spans_top rtl

module tb;
  import asp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FW = 4;
  localparam int PW = CW + FW;
  localparam longint PIX = longint'(1) << FW;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint RAD_MAX = (longint'(1) << (PW - 1)) - 1;

  typedef struct packed {
    logic          first_ok;
    logic [CW-1:0] first_lo;
    logic [CW-1:0] first_hi;
    logic          second_ok;
    logic [CW-1:0] second_lo;
    logic [CW-1:0] second_hi;
  } span_word_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  cfg_reg_e        cfg_index_i = REG_CENTER_X;
  logic [PW-1:0]   cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata = '0;   // line_y
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [63:0]     m_axis_tdata;        // first_start, first_end, second_start, second_end
  logic [1:0]      m_axis_tuser;        // first_valid, second_valid

  // shadow of the block's registers
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint rad_out = 0;
  longint rad_in = 0;
  longint win_left = COORD_MIN;
  longint win_right = COORD_MAX;
  longint win_top = COORD_MIN;
  longint win_bottom = COORD_MAX;

  logic [CW-1:0] line_q[$];
  span_word_t    span_q[$];
  span_word_t    got, want;
  int            errors = 0;
  int            send_gap = 0;
  int            hold_cnt = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  annulus_scanline_spans_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic void add_line(input logic [CW-1:0] v);
    line_q.insert(line_q.size(), v);
  endfunction

  function automatic longint root_floor(input longint n);
    longint r, t;
    r = 0;
    for (int b = PW; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint px_floor(input longint v);
    return (v >= 0) ? v / PIX : -((-v + PIX - 1) / PIX);
  endfunction

  function automatic longint px_ceil(input longint v);
    return (v >= 0) ? (v + PIX - 1) / PIX : -((-v) / PIX);
  endfunction

  function automatic longint clamp_coord(input longint v);
    return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
  endfunction

  function automatic span_word_t annulus_spans(input logic [CW-1:0] line);
    span_word_t r;
    longint y, dy, ady, d, di, ol, orr, il, ir;
    logic ring;
    r = '0;
    ring = 1'b0;
    y = longint'($signed(line));
    if (win_left >= win_right || y < win_top || y >= win_bottom) return r;
    if (px_floor(ctr_x - rad_out) >= win_right || px_ceil(ctr_x + rad_out) <= win_left)
      return r;
    dy = y * PIX - ctr_y;
    ady = (dy < 0) ? -dy : dy;
    if (ady > rad_out) return r;
    d = root_floor(rad_out * rad_out - ady * ady);
    ol = (ctr_x - d) / PIX;
    orr = (ctr_x + d) / PIX;
    if (ol < win_left) ol = win_left;
    if (orr > win_right) orr = win_right;
    if (ady <= rad_in) begin
      di = root_floor(rad_in * rad_in - ady * ady);
      il = (ctr_x - di) / PIX;
      ir = (ctr_x + di) / PIX;
      if (il < ir) begin
        ring = 1'b1;
        il = clamp_coord(il);
        ir = clamp_coord(ir);
        if (ol < il) begin
          r.first_ok = 1'b1;
          r.first_lo = CW'(ol);
          r.first_hi = CW'(il);
        end
        if (ir < orr) begin
          r.second_ok = 1'b1;
          r.second_lo = CW'(ir);
          r.second_hi = CW'(orr);
        end
      end
    end
    if (!ring && ol < orr) begin
      r.first_ok = 1'b1;
      r.first_lo = CW'(ol);
      r.first_hi = CW'(orr);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        span_q.insert(span_q.size(), annulus_spans(s_axis_tdata[CW-1:0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (line_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 12);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= line_q.pop_front();
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.first_ok  = m_axis_tuser[0];
        got.second_ok = m_axis_tuser[1];
        got.first_lo  = m_axis_tdata[15:0];
        got.first_hi  = m_axis_tdata[31:16];
        got.second_lo = m_axis_tdata[47:32];
        got.second_hi = m_axis_tdata[63:48];
        if (span_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word at %0t", $realtime);
        end else begin
          want = span_q.pop_front();
          if (got.first_ok !== want.first_ok || got.first_lo !== want.first_lo ||
              got.first_hi !== want.first_hi || got.second_ok !== want.second_ok ||
              got.second_lo !== want.second_lo || got.second_hi !== want.second_hi) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch at %0t: exp %0b [%0d,%0d) %0b [%0d,%0d)",
                        " got %0b [%0d,%0d) %0b [%0d,%0d)"},
                       $realtime,
                       want.first_ok, $signed(want.first_lo), $signed(want.first_hi),
                       want.second_ok, $signed(want.second_lo), $signed(want.second_hi),
                       got.first_ok, $signed(got.first_lo), $signed(got.first_hi),
                       got.second_ok, $signed(got.second_lo), $signed(got.second_hi));
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        hold_cnt = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [PW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CENTER_X:     ctr_x = longint'($signed(val));
      REG_CENTER_Y:     ctr_y = longint'($signed(val));
      REG_OUTER_RADIUS: rad_out = longint'(val[PW-2:0]);
      REG_INNER_RADIUS: rad_in = longint'(val[PW-2:0]);
      REG_CLIP_LEFT:    win_left = longint'($signed(val[CW-1:0]));
      REG_CLIP_RIGHT:   win_right = longint'($signed(val[CW-1:0]));
      REG_CLIP_TOP:     win_top = longint'($signed(val[CW-1:0]));
      REG_CLIP_BOTTOM:  win_bottom = longint'($signed(val[CW-1:0]));
      default: ;
    endcase
  endtask

  task automatic program_all(input longint cx, cy, ro, ri, cl, cr, ct, cb);
    write_reg(REG_CENTER_X, PW'(cx));
    write_reg(REG_CENTER_Y, PW'(cy));
    write_reg(REG_OUTER_RADIUS, PW'(ro));
    write_reg(REG_INNER_RADIUS, PW'(ri));
    write_reg(REG_CLIP_LEFT, {4'($urandom), CW'(cl)});
    write_reg(REG_CLIP_RIGHT, {4'($urandom), CW'(cr)});
    write_reg(REG_CLIP_TOP, {4'($urandom), CW'(ct)});
    write_reg(REG_CLIP_BOTTOM, {4'($urandom), CW'(cb)});
  endtask

  task automatic drain();
    while (line_q.size() != 0 || s_axis_tvalid || span_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    longint cx, cy, ro, ri, cl, cr, ct, cb, rpx, cpx, ypx, off;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 10;

    // reset values: zero radius
    add_line(16'h8000);
    add_line(16'h7fff);
    add_line(16'h0000);
    drain();

    // ring at (100, 50), radii 40 and 20
    program_all(1600, 800, 640, 320, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    add_line(16'd50);
    add_line(16'd10);
    add_line(16'd9);
    add_line(16'd30);
    add_line(16'd40);
    add_line(16'd90);
    add_line(16'd91);
    drain();

    // tight clip window
    program_all(1600, 800, 640, 320, 80, 120, 45, 55);
    add_line(16'd44);
    add_line(16'd45);
    add_line(16'd54);
    add_line(16'd55);
    add_line(16'd50);
    drain();

    // empty clip
    program_all(1600, 800, 640, 320, 100, 100, COORD_MIN, COORD_MAX);
    add_line(16'd50);
    drain();

    // object box left of the clip
    program_all(1600, 800, 640, 320, 200, 300, COORD_MIN, COORD_MAX);
    add_line(16'd50);
    drain();

    // inner radius larger than outer
    program_all(1600, 800, 640, 700, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    add_line(16'd50);
    add_line(16'd35);
    drain();

    // extreme center and radii, inner ends saturate
    program_all(RAD_MAX, 0, RAD_MAX, 400000, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    add_line(16'd0);
    add_line(16'h7fff);
    drain();
    program_all(-RAD_MAX - 1, -RAD_MAX - 1, RAD_MAX, RAD_MAX,
                COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    add_line(16'h8000);
    add_line(16'd0);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      cx = longint'($signed(PW'($urandom)));
      cy = longint'($signed(PW'($urandom)));
      case ($urandom_range(0, 3))
        0: ro = $urandom_range(0, 255);
        1: ro = $urandom_range(0, 16000);
        2: ro = $urandom_range(0, RAD_MAX);
        default: ro = ($urandom_range(0, 1) != 0) ? RAD_MAX : 0;
      endcase
      case ($urandom_range(0, 4))
        0: ri = 0;
        1, 2: ri = $urandom_range(0, ro);
        3: ri = ro + $urandom_range(0, 64);
        default: ri = $urandom_range(0, RAD_MAX);
      endcase
      if (ri > RAD_MAX) ri = RAD_MAX;
      rpx = ro >>> FW;
      cpx = cx >>> FW;
      ypx = cy >>> FW;
      case ($urandom_range(0, 3))
        0: begin
          cl = COORD_MIN;
          cr = COORD_MAX;
          ct = COORD_MIN;
          cb = COORD_MAX;
        end
        1: begin
          cl = cpx - $urandom_range(0, rpx + 8);
          cr = cpx + $urandom_range(0, rpx + 8);
          ct = ypx - $urandom_range(0, rpx + 8);
          cb = ypx + $urandom_range(0, rpx + 8);
        end
        2: begin
          cl = longint'($signed(CW'($urandom)));
          cr = longint'($signed(CW'($urandom)));
          ct = longint'($signed(CW'($urandom)));
          cb = longint'($signed(CW'($urandom)));
        end
        default: begin
          cl = cpx - $urandom_range(0, rpx + 8);
          cr = COORD_MAX;
          ct = COORD_MIN;
          cb = ypx + $urandom_range(0, rpx + 8);
        end
      endcase
      if (ph >= 17) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 3;
          default: send_idle_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 3;
          default: recv_idle_pct = 25;
        endcase
      end
      program_all(cx, cy, ro, ri, cl, cr, ct, cb);
      for (int i = 0; i < 92; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          add_line(CW'($urandom));
        end else begin
          off = $urandom_range(0, 2 * rpx + 8);
          add_line(CW'(ypx + off - rpx - 4));
        end
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    errors += span_q.size();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
